// File: rtl/itm_pkg.sv
package itm_pkg;

  localparam logic [2:0] ACT_ADD       = 3'd0;
  localparam logic [2:0] ACT_REMOVE    = 3'd1;
  localparam logic [2:0] ACT_CLEAR     = 3'd2;
  localparam logic [2:0] ACT_SET_LEFT  = 3'd3;
  localparam logic [2:0] ACT_SET_RIGHT = 3'd4;
  localparam logic [2:0] ACT_QUERY     = 3'd5;

  localparam logic [2:0] EV_ADDED    = 3'd0;
  localparam logic [2:0] EV_REMOVED  = 3'd1;
  localparam logic [2:0] EV_MODIFIED = 3'd2;
  localparam logic [2:0] EV_QUERY    = 3'd3;
  localparam logic [2:0] EV_FULL     = 3'd4;

  localparam int MAX_RESULTS = 16;

  typedef struct packed {
    logic shift_en;
    logic wr_s;
    logic wr_f;
  } cell_ctl_t;

  typedef struct packed {
    logic contain;
    logic swallowed;
    logic lt_hit;
    logic rt_hit;
    logic q_hit;
  } cell_flags_t;

  typedef enum logic [9:0] {
    ST_IDLE    = 10'b0000000001,
    ST_DEC     = 10'b0000000010,
    ST_ACHK    = 10'b0000000100,
    ST_ADROP   = 10'b0000001000,
    ST_AMERGE  = 10'b0000010000,
    ST_ADROPRT = 10'b0000100000,
    ST_SCAN    = 10'b0001000000,
    ST_SDEC    = 10'b0010000000,
    ST_CLR     = 10'b0100000000,
    ST_EMIT    = 10'b1000000000
  } state_t;

endpackage

// File: rtl/interval_table_merge.sv
// Channel   Dir  Payload
// s_axis    in   tuser: action; tdata: new_begin, new_end, position, slot_index
// m_axis    out  tuser: event_res; tdata: seg_begin, seg_end, can_start; tlast: last
//
// The set-bound actions scan the cell row one entry a cycle, each silently dropped
// interval costs one shift of the row, and clear emits one result per cycle while m_axis
// is not stalled. rst clears the entry count and the control state; the cell contents stay
// undefined. A stalled m_axis holds the result register and stops the sequencer in its
// clear and emit states; s_axis is ready only while idle.
module interval_table_merge #(
  parameter int CAPACITY       = 16,
  parameter int POSITION_WIDTH = 24
) (
  input  logic clk,
  input  logic rst,
  input  logic s_tvalid,
  output logic s_tready,
  input  logic [2:0] s_tuser, // action
  // new_begin, new_end, position, slot_index
  input  logic [((3*POSITION_WIDTH+4+7)/8)*8-1:0] s_tdata,
  output logic m_tvalid,
  input  logic m_tready,
  output logic [2:0] m_tuser, // event_res
  // seg_begin, seg_end, can_start
  output logic [((2*POSITION_WIDTH+1+7)/8)*8-1:0] m_tdata,
  output logic m_tlast
);
  import itm_pkg::*;

  localparam int PW  = POSITION_WIDTH;
  localparam int IW  = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW  = $clog2(CAPACITY + 1);
  localparam int IDW = ((3*PW+4+7)/8)*8;
  localparam int ODW = ((2*PW+1+7)/8)*8;

  state_t state;
  logic [2:0]    act;
  logic [PW-1:0] b, e, pos;
  logic [3:0]    slot;
  logic [CW-1:0] count;
  logic [CW-1:0] i;
  logic [IW-1:0] best, rt_reg;
  logic [PW-1:0] best_v;
  logic          found;
  logic [CAPACITY-1:0] mark;
  logic [2:0]    res_ev;
  logic [PW-1:0] res_b, res_e;
  logic          res_cs;
  logic          ovalid, olast, ocan;
  logic [2:0]    oev;
  logic [PW-1:0] ob, oe;

  cell_ctl_t     ctl;
  logic [IW-1:0] shift_at, wr_at;
  logic [PW-1:0] wr_s_val, wr_f_val;
  logic [PW-1:0] cs [CAPACITY];
  logic [PW-1:0] cf [CAPACITY];
  cell_flags_t   fl [CAPACITY];

  logic [CAPACITY-1:0] contain_v, swallowed_v, ltv, rtv, q_v;
  logic [IW-1:0] k, lt, rt, rd_idx;
  logic          lt_any, rt_any;
  logic [PW-1:0] s_lt, f_rt, rd_s, rd_f;
  logic          out_free, slot_ok, clr_last, o_load;
  logic [CW:0]   ip1;

  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    itm_cell #(.PW(PW), .IW(IW), .CW(CW), .IDX(g)) u_cell (
      .clk      (clk),
      .ctl      (ctl),
      .shift_at (shift_at),
      .wr_at    (wr_at),
      .wr_s_val (wr_s_val),
      .wr_f_val (wr_f_val),
      .s_in     (cs[(g + 1 < CAPACITY) ? g + 1 : g]),
      .f_in     (cf[(g + 1 < CAPACITY) ? g + 1 : g]),
      .b        (b),
      .e        (e),
      .pos      (pos),
      .count    (count),
      .s        (cs[g]),
      .f        (cf[g]),
      .flags    (fl[g])
    );
    assign contain_v[g]   = fl[g].contain;
    assign swallowed_v[g] = fl[g].swallowed;
    assign ltv[g]         = fl[g].lt_hit;
    assign rtv[g]         = fl[g].rt_hit && !fl[g].lt_hit;
    assign q_v[g]         = fl[g].q_hit;
  end

  always_comb begin
    k  = '0;
    lt = '0;
    rt = '0;
    for (int n = CAPACITY - 1; n >= 0; n--) begin
      if (mark[n]) k = IW'(n);
    end
    for (int n = 0; n < CAPACITY; n++) begin
      if (ltv[n]) lt = IW'(n);
      if (rtv[n]) rt = IW'(n);
    end
  end

  assign lt_any   = |ltv;
  assign rt_any   = |rtv;
  assign s_lt     = cs[lt];
  assign f_rt     = cf[rt];
  assign rd_idx   = (state == ST_SCAN) ? i[IW-1:0] : best;
  assign rd_s     = cs[rd_idx];
  assign rd_f     = cf[rd_idx];
  assign out_free = !ovalid || m_tready;
  assign o_load   = out_free && (state == ST_CLR || state == ST_EMIT);
  assign slot_ok  = 32'(slot) < 32'(count);
  assign ip1      = {1'b0, i} + 1'b1;
  assign clr_last = ip1 == {1'b0, count} || 32'(ip1) == MAX_RESULTS;

  always_comb begin
    ctl      = '0;
    shift_at = '0;
    wr_at    = '0;
    wr_s_val = b;
    wr_f_val = e;
    unique case (state)
      ST_DEC: begin
        if (act == ACT_REMOVE && slot_ok) begin
          ctl.shift_en = 1'b1;
          shift_at     = IW'(slot);
        end
      end
      ST_ADROP: begin
        if (mark != '0) begin
          ctl.shift_en = 1'b1;
          shift_at     = k;
        end
      end
      ST_AMERGE: begin
        if (lt_any && rt_any) begin
          ctl.wr_f = 1'b1;
          wr_at    = lt;
          wr_f_val = f_rt;
        end else if (lt_any) begin
          ctl.wr_f = 1'b1;
          wr_at    = lt;
        end else if (rt_any) begin
          ctl.wr_s = 1'b1;
          wr_at    = rt;
        end else if (32'(count) < CAPACITY) begin
          ctl.wr_s = 1'b1;
          ctl.wr_f = 1'b1;
          wr_at    = count[IW-1:0];
        end
      end
      ST_ADROPRT: begin
        ctl.shift_en = 1'b1;
        shift_at     = rt_reg;
      end
      ST_SDEC: begin
        wr_at    = best;
        wr_s_val = pos;
        wr_f_val = pos;
        if (found && act == ACT_SET_LEFT && !(pos < rd_s)) ctl.wr_s = 1'b1;
        if (found && act == ACT_SET_RIGHT && !(rd_f < pos)) ctl.wr_f = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= ST_IDLE;
      count  <= '0;
      ovalid <= 1'b0;
    end else begin
      if (m_tvalid && m_tready && !o_load) ovalid <= 1'b0;
      if (ctl.shift_en) count <= count - 1'b1;
      unique case (state)
        ST_IDLE: begin
          if (s_tvalid) begin
            act   <= s_tuser;
            b     <= s_tdata[PW-1:0];
            e     <= s_tdata[2*PW-1:PW];
            pos   <= s_tdata[3*PW-1:2*PW];
            slot  <= s_tdata[3*PW+3:3*PW];
            i     <= '0;
            found <= 1'b0;
            state <= ST_DEC;
          end
        end
        ST_DEC: begin
          unique case (act)
            ACT_ADD: state <= ST_ACHK;
            ACT_REMOVE: begin
              if (slot_ok) begin
                res_ev <= EV_REMOVED;
                res_b  <= cs[IW'(slot)];
                res_e  <= cf[IW'(slot)];
                res_cs <= 1'b0;
                state  <= ST_EMIT;
              end else begin
                state <= ST_IDLE;
              end
            end
            ACT_CLEAR: state <= (count == '0) ? ST_IDLE : ST_CLR;
            ACT_SET_LEFT, ACT_SET_RIGHT: state <= ST_SCAN;
            ACT_QUERY: begin
              res_ev <= EV_QUERY;
              res_b  <= '0;
              res_e  <= '0;
              res_cs <= ~|q_v;
              state  <= ST_EMIT;
            end
            default: state <= ST_IDLE;
          endcase
        end
        ST_ACHK: begin
          mark  <= swallowed_v;
          state <= (|contain_v) ? ST_IDLE : ST_ADROP;
        end
        ST_ADROP: begin
          // drop the lowest marked entry, realign marks with the shifted row
          if (mark != '0) mark <= (mark & ~(CAPACITY'(1) << k)) >> 1;
          else state <= ST_AMERGE;
        end
        ST_AMERGE: begin
          res_cs <= 1'b0;
          if (lt_any && rt_any) begin
            res_ev <= EV_ADDED;
            res_b  <= s_lt;
            res_e  <= f_rt;
            rt_reg <= rt;
            state  <= ST_ADROPRT;
          end else if (lt_any) begin
            res_ev <= EV_ADDED;
            res_b  <= s_lt;
            res_e  <= e;
            state  <= ST_EMIT;
          end else if (rt_any) begin
            res_ev <= EV_ADDED;
            res_b  <= b;
            res_e  <= f_rt;
            state  <= ST_EMIT;
          end else begin
            res_b <= b;
            res_e <= e;
            state <= ST_EMIT;
            if (32'(count) < CAPACITY) begin
              count  <= count + 1'b1;
              res_ev <= EV_ADDED;
            end else begin
              res_ev <= EV_FULL;
            end
          end
        end
        ST_ADROPRT: state <= ST_EMIT;
        ST_SCAN: begin
          if (i == count) begin
            state <= ST_SDEC;
          end else begin
            i <= i + 1'b1;
            if (act == ACT_SET_LEFT) begin
              if (pos < rd_f && (!found || rd_f < best_v)) begin
                best   <= i[IW-1:0];
                best_v <= rd_f;
                found  <= 1'b1;
              end
            end else if (rd_s < pos && (!found || rd_s > best_v)) begin
              best   <= i[IW-1:0];
              best_v <= rd_s;
              found  <= 1'b1;
            end
          end
        end
        ST_SDEC: begin
          res_ev <= EV_MODIFIED;
          res_cs <= 1'b0;
          if (!found) begin
            state <= ST_IDLE;
          end else if (act == ACT_SET_LEFT) begin
            if (pos < rd_s) begin
              b     <= pos;
              e     <= rd_f;
              state <= ST_ACHK;
            end else begin
              res_b <= pos;
              res_e <= rd_f;
              state <= ST_EMIT;
            end
          end else begin
            if (rd_f < pos) begin
              b     <= rd_s;
              e     <= pos;
              state <= ST_ACHK;
            end else begin
              res_b <= rd_s;
              res_e <= pos;
              state <= ST_EMIT;
            end
          end
        end
        ST_CLR: begin
          if (out_free) begin
            ovalid <= 1'b1;
            oev    <= EV_REMOVED;
            ob     <= cs[i[IW-1:0]];
            oe     <= cf[i[IW-1:0]];
            ocan   <= 1'b0;
            olast  <= clr_last;
            i      <= i + 1'b1;
            if (clr_last) begin
              count <= '0;
              state <= ST_IDLE;
            end
          end
        end
        ST_EMIT: begin
          if (out_free) begin
            ovalid <= 1'b1;
            oev    <= res_ev;
            ob     <= res_b;
            oe     <= res_e;
            ocan   <= res_cs;
            olast  <= 1'b1;
            state  <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  assign s_tready = state == ST_IDLE;
  assign m_tvalid = ovalid;
  assign m_tuser  = oev;
  assign m_tlast  = olast;
  assign m_tdata  = ODW'({ocan, oe, ob});

endmodule

// File: rtl/itm_cell.sv
module itm_cell #(
  parameter int PW  = 24,
  parameter int IW  = 4,
  parameter int CW  = 5,
  parameter int IDX = 0
) (
  input  logic              clk,
  input  itm_pkg::cell_ctl_t ctl,
  input  logic [IW-1:0]     shift_at,
  input  logic [IW-1:0]     wr_at,
  input  logic [PW-1:0]     wr_s_val,
  input  logic [PW-1:0]     wr_f_val,
  input  logic [PW-1:0]     s_in,
  input  logic [PW-1:0]     f_in,
  input  logic [PW-1:0]     b,
  input  logic [PW-1:0]     e,
  input  logic [PW-1:0]     pos,
  input  logic [CW-1:0]     count,
  output logic [PW-1:0]     s,
  output logic [PW-1:0]     f,
  output itm_pkg::cell_flags_t flags
);
  import itm_pkg::*;

  logic valid;
  logic here;

  assign valid = CW'(IDX) < count;
  assign here  = wr_at == IW'(IDX);

  always_ff @(posedge clk) begin
    if (ctl.shift_en && IW'(IDX) >= shift_at) begin
      s <= s_in;
      f <= f_in;
    end else begin
      if (ctl.wr_s && here) s <= wr_s_val;
      if (ctl.wr_f && here) f <= wr_f_val;
    end
  end

  assign flags.contain   = valid && s <= b && e <= f;
  assign flags.swallowed = valid && b < s && f < e;
  assign flags.lt_hit    = valid && s <= b && b <= f;
  assign flags.rt_hit    = valid && s <= e && e <= f;
  assign flags.q_hit     = valid && s < pos && pos < f;

endmodule

// File: verif/interval_table_checker.sv
`timescale 1ns / 100ps

module interval_table_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [2:0]  s_tuser,
  input  logic [79:0] s_tdata,
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [2:0]  m_tuser,
  input  logic [55:0] m_tdata,
  input  logic        m_tlast,
  output int          fail_count,
  output int          pending
);
  import itm_pkg::*;

  localparam int DEPTH = 16;

  typedef struct packed {
    logic [2:0]  ev;
    logic [23:0] seg_b;
    logic [23:0] seg_e;
    logic        free;
    logic        tail;
  } event_t;

  logic [23:0] lo_tab[DEPTH];
  logic [23:0] hi_tab[DEPTH];
  int          used;
  event_t      events_due[$];
  event_t      step_out[$];

  assign pending = events_due.size();

  function automatic event_t mk(logic [2:0] ev, logic [23:0] b, logic [23:0] e, logic f);
    event_t r;
    r.ev = ev; r.seg_b = b; r.seg_e = e; r.free = f; r.tail = 1'b0;
    return r;
  endfunction

  task automatic delete_entry(int idx);
    if (idx < used) begin
      for (int i = idx; i + 1 < used; i++) begin
        lo_tab[i] = lo_tab[i+1];
        hi_tab[i] = hi_tab[i+1];
      end
      used--;
    end
  endtask

  task automatic insert_interval(logic [23:0] b, logic [23:0] e);
    int lt, rt, i;
    lt = -1; rt = -1;
    for (i = 0; i < used; i++)
      if (lo_tab[i] <= b && e <= hi_tab[i]) return;
    i = 0;
    while (i < used) begin
      if (b < lo_tab[i] && hi_tab[i] < e) delete_entry(i);
      else i++;
    end
    for (i = 0; i < used; i++) begin
      if (lo_tab[i] <= b && b <= hi_tab[i]) lt = i;
      else if (lo_tab[i] <= e && e <= hi_tab[i]) rt = i;
    end
    if (lt >= 0 && rt >= 0) begin
      hi_tab[lt] = hi_tab[rt];
      step_out.push_back(mk(EV_ADDED, lo_tab[lt], hi_tab[rt], 1'b0));
      delete_entry(rt);
    end else if (lt >= 0) begin
      hi_tab[lt] = e;
      step_out.push_back(mk(EV_ADDED, lo_tab[lt], e, 1'b0));
    end else if (rt >= 0) begin
      lo_tab[rt] = b;
      step_out.push_back(mk(EV_ADDED, b, hi_tab[rt], 1'b0));
    end else if (used < DEPTH) begin
      lo_tab[used] = b;
      hi_tab[used] = e;
      used++;
      step_out.push_back(mk(EV_ADDED, b, e, 1'b0));
    end else begin
      step_out.push_back(mk(EV_FULL, b, e, 1'b0));
    end
  endtask

  task automatic apply_request(logic [2:0] act, logic [79:0] d);
    logic [23:0] nb, ne, pos;
    logic [3:0]  slot;
    int          best;
    logic        free;
    nb = d[23:0]; ne = d[47:24]; pos = d[71:48]; slot = d[75:72];
    best = -1;
    step_out.delete();
    case (act)
      ACT_ADD: insert_interval(nb, ne);
      ACT_REMOVE: begin
        if (slot < used) begin
          step_out.push_back(mk(EV_REMOVED, lo_tab[slot], hi_tab[slot], 1'b0));
          delete_entry(slot);
        end
      end
      ACT_CLEAR: begin
        for (int i = 0; i < used; i++)
          if (i < MAX_RESULTS) step_out.push_back(mk(EV_REMOVED, lo_tab[i], hi_tab[i], 1'b0));
        used = 0;
      end
      ACT_SET_LEFT: begin
        for (int i = 0; i < used; i++)
          if (pos < hi_tab[i] && (best < 0 || hi_tab[i] < hi_tab[best])) best = i;
        if (best >= 0) begin
          if (pos < lo_tab[best]) insert_interval(pos, hi_tab[best]);
          else begin
            lo_tab[best] = pos;
            step_out.push_back(mk(EV_MODIFIED, pos, hi_tab[best], 1'b0));
          end
        end
      end
      ACT_SET_RIGHT: begin
        for (int i = 0; i < used; i++)
          if (lo_tab[i] < pos && (best < 0 || lo_tab[i] > lo_tab[best])) best = i;
        if (best >= 0) begin
          if (hi_tab[best] < pos) insert_interval(lo_tab[best], pos);
          else begin
            hi_tab[best] = pos;
            step_out.push_back(mk(EV_MODIFIED, lo_tab[best], pos, 1'b0));
          end
        end
      end
      ACT_QUERY: begin
        free = 1'b1;
        for (int i = 0; i < used; i++)
          if (lo_tab[i] < pos && pos < hi_tab[i]) free = 1'b0;
        step_out.push_back(mk(EV_QUERY, '0, '0, free));
      end
      default: ;
    endcase
    if (step_out.size() > 0) step_out[step_out.size()-1].tail = 1'b1;
    foreach (step_out[k]) events_due.push_back(step_out[k]);
  endtask

  always @(posedge clk) begin
    event_t want;
    if (rst) begin
      used = 0;
      fail_count <= 0;
      events_due.delete();
    end else begin
      if (m_tvalid && m_tready) begin
        if (events_due.size() == 0) begin
          $error("unexpected result: event %0d", m_tuser);
          fail_count <= fail_count + 1;
        end else begin
          want = events_due.pop_front();
          if (m_tuser !== want.ev || m_tdata[23:0] !== want.seg_b ||
              m_tdata[47:24] !== want.seg_e || m_tdata[48] !== want.free ||
              m_tlast !== want.tail) begin
            if (m_tuser !== want.ev)
              $error("event_res: expected %0d, got %0d", want.ev, m_tuser);
            if (m_tdata[23:0] !== want.seg_b)
              $error("seg_begin: expected %0h, got %0h", want.seg_b, m_tdata[23:0]);
            if (m_tdata[47:24] !== want.seg_e)
              $error("seg_end: expected %0h, got %0h", want.seg_e, m_tdata[47:24]);
            if (m_tdata[48] !== want.free)
              $error("can_start: expected %0b, got %0b", want.free, m_tdata[48]);
            if (m_tlast !== want.tail)
              $error("last: expected %0b, got %0b", want.tail, m_tlast);
            fail_count <= fail_count + 1;
          end
        end
      end
      // predict after popping so a same-cycle result is matched first
      if (s_tvalid && s_tready) apply_request(s_tuser, s_tdata);
    end
  end

endmodule

// File: verif/testbench.sv
`timescale 1ns / 100ps

module testbench;
  import itm_pkg::*;

  localparam int CYCLE_LIMIT = 400000;

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [2:0]  s_tuser;
  logic [79:0] s_tdata;
  logic        m_tvalid;
  logic        m_tready;
  logic [2:0]  m_tuser;
  logic [55:0] m_tdata;
  logic        m_tlast;
  int          fail_count;
  int          pending;
  int          send_idle;
  int          recv_idle;
  int          cycles;
  logic [23:0] anchors[8];

  interval_table_merge u_dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tuser(s_tuser), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tuser(m_tuser), .m_tdata(m_tdata),
    .m_tlast(m_tlast)
  );

  interval_table_checker u_checker (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tuser(s_tuser), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tuser(m_tuser), .m_tdata(m_tdata),
    .m_tlast(m_tlast), .fail_count(fail_count), .pending(pending)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    m_tready <= ($urandom_range(99) >= recv_idle);
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // hold valid through back-to-back requests, drop it only while idling
  task automatic send_request(logic [2:0] act, logic [23:0] nb, logic [23:0] ne,
                              logic [23:0] pos, logic [3:0] slot);
    while ($urandom_range(99) < send_idle) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= act;
    s_tdata  <= {4'b0, slot, pos, ne, nb};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  // positions cluster near a few anchors so merges and containment happen often
  function automatic logic [23:0] pick_pos();
    case ($urandom_range(3))
      0: return 24'($urandom);
      default: return 24'(anchors[$urandom_range(7)] + $urandom_range(40) - 20);
    endcase
  endfunction

  task automatic random_request();
    logic [23:0] b, e;
    int r;
    r = $urandom_range(99);
    b = pick_pos();
    e = ($urandom_range(9) == 0) ? pick_pos() : 24'(b + $urandom_range(30));
    if (r < 40)
      send_request(ACT_ADD, b, e, 24'($urandom), 4'($urandom));
    else if (r < 50)
      send_request(ACT_REMOVE, 24'($urandom), 24'($urandom), 24'($urandom), 4'($urandom));
    else if (r < 53)
      send_request(ACT_CLEAR, 24'($urandom), 24'($urandom), 24'($urandom), 4'($urandom));
    else if (r < 66)
      send_request(ACT_SET_LEFT, 24'($urandom), 24'($urandom), b, 4'($urandom));
    else if (r < 79)
      send_request(ACT_SET_RIGHT, 24'($urandom), 24'($urandom), b, 4'($urandom));
    else if (r < 97)
      send_request(ACT_QUERY, 24'($urandom), 24'($urandom), b, 4'($urandom));
    else
      send_request(3'(6 + $urandom_range(1)), 24'($urandom), 24'($urandom),
                   24'($urandom), 4'($urandom));
  endtask

  initial begin
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tuser = '0;
    s_tdata = '0;
    m_tready = 1'b0;
    cycles = 0;
    send_idle = 17;
    recv_idle = 66;
    foreach (anchors[k]) anchors[k] = 24'($urandom);
    anchors[0] = 24'd20;
    anchors[1] = 24'hFFFFE0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: extremes, contained add, merges, reversed, full table, remove, clear
    send_request(ACT_QUERY, '0, '0, 24'd5, '0);
    send_request(ACT_SET_LEFT, '0, '0, 24'd5, '0);
    send_request(ACT_ADD, 24'd0, 24'hFFFFFF, '0, '0);
    send_request(ACT_ADD, 24'd10, 24'd20, '0, '0);
    send_request(ACT_QUERY, '0, '0, 24'd0, '0);
    send_request(ACT_QUERY, '0, '0, 24'd7, '0);
    send_request(ACT_REMOVE, '0, '0, '0, 4'd15);
    send_request(ACT_REMOVE, '0, '0, '0, 4'd0);
    send_request(ACT_ADD, 24'd10, 24'd20, '0, '0);
    send_request(ACT_ADD, 24'd30, 24'd40, '0, '0);
    send_request(ACT_ADD, 24'd20, 24'd30, '0, '0);
    send_request(ACT_ADD, 24'd5, 24'd12, '0, '0);
    send_request(ACT_ADD, 24'd1, 24'd50, '0, '0);
    send_request(ACT_ADD, 24'd90, 24'd80, '0, '0);
    send_request(ACT_SET_LEFT, '0, '0, 24'd3, '0);
    send_request(ACT_SET_RIGHT, '0, '0, 24'd60, '0);
    send_request(ACT_SET_RIGHT, '0, '0, 24'hFFFFFF, '0);
    send_request(3'd7, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 4'hF);
    for (int i = 0; i < 17; i++)
      send_request(ACT_ADD, 24'd1000 + 24'(i) * 24'd100, 24'd1010 + 24'(i) * 24'd100,
                   '0, '0);
    send_request(ACT_REMOVE, '0, '0, '0, 4'd15);
    send_request(ACT_CLEAR, '0, '0, '0, '0);

    for (int n = 0; n < 440; n++) begin
      if (n == 150) begin send_idle = 66; recv_idle = 17; end
      if (n == 300) begin send_idle = 0; recv_idle = 0; end
      random_request();
    end
    s_tvalid <= 1'b0;

    while (pending != 0) @(posedge clk);
    repeat (60) @(posedge clk);
    if (fail_count == 0 && pending == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end

endmodule
